/* design/nearest_neighbor_scale_address_gen_unit_assert.svh */
// Assertion macros used by the address generator controller
`ifndef NEAREST_NEIGHBOR_SCALE_ADDRESS_GEN_UNIT_ASSERT_SVH
`define NEAREST_NEIGHBOR_SCALE_ADDRESS_GEN_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define NNSAG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define NNSAG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/nnsag_pkg.sv */
// Shared constants and types of the nearest-neighbor scale address generator
package nnsag_pkg;

  localparam int DIM_BITS     = 12;
  localparam int ADDR_BITS    = 24;
  localparam int ERR_BITS     = DIM_BITS + 3;
  localparam int DIV_CNT_BITS = $clog2(DIM_BITS);
  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_SRC_BASE   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DST_BASE   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SRC_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SRC_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DST_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DST_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_SRC_STRIDE = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_DST_STRIDE = 3'd7;

  typedef logic [DIM_BITS-1:0]         dim_t;
  typedef logic [ADDR_BITS-1:0]        addr_t;
  typedef logic signed [ERR_BITS-1:0]  err_t;

  typedef struct packed {
    logic div_start;
    logic div_sel_y;
    logic cap_x;
    logic cap_y;
    logic setup;
    logic emit;
    logic stop;
  } cmd_t;

  typedef struct packed {
    logic sizes_zero;
    logic div_done;
    logic frame_active;
    logic out_busy;
  } status_t;

endpackage

/* design/nnsag_div.sv */
// Restoring divider, one quotient bit per cycle
module nnsag_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  nnsag_pkg::dim_t  num,
  input  nnsag_pkg::dim_t  den,
  output logic             done,
  output nnsag_pkg::dim_t  quo,
  output nnsag_pkg::dim_t  rem
);

  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic [nnsag_pkg::DIV_CNT_BITS-1:0]  cnt_r, cnt_nxt;
  nnsag_pkg::dim_t                     quo_r, quo_nxt;
  nnsag_pkg::dim_t                     rem_r, rem_nxt;
  nnsag_pkg::dim_t                     den_r, den_nxt;
  logic [nnsag_pkg::DIM_BITS:0]        trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    trial    = {rem_r, quo_r[nnsag_pkg::DIM_BITS-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = nnsag_pkg::DIV_CNT_BITS'(nnsag_pkg::DIM_BITS - 1);
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = nnsag_pkg::DIM_BITS'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[nnsag_pkg::DIM_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[nnsag_pkg::DIM_BITS-1:0];
        quo_nxt = {quo_r[nnsag_pkg::DIM_BITS-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

/* design/nnsag_dp.sv */
// Datapath: registers, set-up arithmetic, Bresenham stepper and output register
module nnsag_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [nnsag_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  nnsag_pkg::addr_t                     cfg_wdata,
  input  nnsag_pkg::cmd_t                      cmd,
  output nnsag_pkg::status_t                   sts,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output nnsag_pkg::addr_t                     out_src_address,
  output nnsag_pkg::addr_t                     out_dst_address,
  output logic                                 out_row_end,
  output logic                                 out_frame_end
);

  nnsag_pkg::addr_t src_base_r, dst_base_r;
  nnsag_pkg::dim_t  src_width_r, src_height_r, dst_width_r, dst_height_r;
  nnsag_pkg::dim_t  src_stride_r, dst_stride_r;

  logic             div_done;
  nnsag_pkg::dim_t  div_quo, div_rem, div_num, div_den;

  nnsag_pkg::dim_t                 x_skip_r, spy_r, lat_dst_width_r;
  nnsag_pkg::dim_t                 lat_src_stride_r, lat_dst_stride_r;
  logic [nnsag_pkg::DIM_BITS:0]    x_inc_r, y_inc_r, x_den_r, y_den_r;
  nnsag_pkg::addr_t                row_skip_r;
  nnsag_pkg::addr_t                src_row_r, src_addr_r, dst_row_r, dst_addr_r;
  nnsag_pkg::addr_t                src_row_nxt, src_addr_nxt, dst_row_nxt, dst_addr_nxt;
  nnsag_pkg::err_t                 x_err_r, y_err_r, x_err_nxt, y_err_nxt;
  nnsag_pkg::err_t                 x_sum, y_sum;
  logic                            x_step, y_step;
  nnsag_pkg::dim_t                 cols_r, rows_r, cols_nxt, rows_nxt;
  logic                            frame_active_r, frame_active_nxt;
  logic [2*nnsag_pkg::DIM_BITS-1:0] product;

  logic             out_valid_r;
  nnsag_pkg::addr_t out_src_r, out_dst_r;
  logic             out_row_end_r, out_frame_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_base_r   <= '0;
      dst_base_r   <= '0;
      src_width_r  <= '0;
      src_height_r <= '0;
      dst_width_r  <= '0;
      dst_height_r <= '0;
      src_stride_r <= '0;
      dst_stride_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nnsag_pkg::REG_SRC_BASE:   src_base_r   <= cfg_wdata;
        nnsag_pkg::REG_DST_BASE:   dst_base_r   <= cfg_wdata;
        nnsag_pkg::REG_SRC_WIDTH:  src_width_r  <= cfg_wdata[nnsag_pkg::DIM_BITS-1:0];
        nnsag_pkg::REG_SRC_HEIGHT: src_height_r <= cfg_wdata[nnsag_pkg::DIM_BITS-1:0];
        nnsag_pkg::REG_DST_WIDTH:  dst_width_r  <= cfg_wdata[nnsag_pkg::DIM_BITS-1:0];
        nnsag_pkg::REG_DST_HEIGHT: dst_height_r <= cfg_wdata[nnsag_pkg::DIM_BITS-1:0];
        nnsag_pkg::REG_SRC_STRIDE: src_stride_r <= cfg_wdata[nnsag_pkg::DIM_BITS-1:0];
        nnsag_pkg::REG_DST_STRIDE: dst_stride_r <= cfg_wdata[nnsag_pkg::DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign div_num = cmd.div_sel_y ? src_height_r : src_width_r;
  assign div_den = cmd.div_sel_y ? dst_height_r : dst_width_r;

  nnsag_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // whole-pixel and whole-row skips apply only when shrinking
  always_ff @(posedge clk) begin
    if (cmd.cap_x) begin
      if (dst_width_r < src_width_r) begin
        x_skip_r <= div_quo;
        x_inc_r  <= {div_rem, 1'b0};
      end else begin
        x_skip_r <= '0;
        x_inc_r  <= {src_width_r, 1'b0};
      end
    end
    if (cmd.cap_y) begin
      if (dst_height_r < src_height_r) begin
        spy_r   <= div_quo;
        y_inc_r <= {div_rem, 1'b0};
      end else begin
        spy_r   <= '0;
        y_inc_r <= {src_height_r, 1'b0};
      end
    end
    if (cmd.setup) begin
      row_skip_r       <= nnsag_pkg::ADDR_BITS'(product);
      x_den_r          <= {dst_width_r, 1'b0};
      y_den_r          <= {dst_height_r, 1'b0};
      lat_src_stride_r <= src_stride_r;
      lat_dst_stride_r <= dst_stride_r;
      lat_dst_width_r  <= dst_width_r;
    end
  end

  assign product = spy_r * src_stride_r;

  assign x_sum  = x_err_r + $signed({2'b00, x_inc_r});
  assign y_sum  = y_err_r + $signed({2'b00, y_inc_r});
  assign x_step = !x_sum[nnsag_pkg::ERR_BITS-1] && (x_sum != '0);
  assign y_step = !y_sum[nnsag_pkg::ERR_BITS-1] && (y_sum != '0);

  always_comb begin
    src_row_nxt      = src_row_r;
    src_addr_nxt     = src_addr_r;
    dst_row_nxt      = dst_row_r;
    dst_addr_nxt     = dst_addr_r;
    x_err_nxt        = x_err_r;
    y_err_nxt        = y_err_r;
    cols_nxt         = cols_r;
    rows_nxt         = rows_r;
    frame_active_nxt = frame_active_r;
    if (cmd.stop) begin
      frame_active_nxt = 1'b0;
      cols_nxt         = '0;
      rows_nxt         = '0;
    end else if (cmd.setup) begin
      src_row_nxt      = src_base_r;
      src_addr_nxt     = src_base_r;
      dst_row_nxt      = dst_base_r;
      dst_addr_nxt     = dst_base_r;
      x_err_nxt        = -$signed({2'b00, dst_width_r, 1'b0});
      y_err_nxt        = -$signed({2'b00, dst_height_r, 1'b0});
      cols_nxt         = dst_width_r;
      rows_nxt         = dst_height_r;
      frame_active_nxt = 1'b1;
    end else if (cmd.emit) begin
      if (cols_r > nnsag_pkg::DIM_BITS'(1)) begin
        cols_nxt     = cols_r - 1'b1;
        src_addr_nxt = src_addr_r + nnsag_pkg::ADDR_BITS'(x_skip_r)
                       + nnsag_pkg::ADDR_BITS'(x_step);
        x_err_nxt    = x_step ? (x_sum - $signed({2'b00, x_den_r})) : x_sum;
        dst_addr_nxt = dst_addr_r + 1'b1;
      end else begin
        rows_nxt = rows_r - 1'b1;
        if (rows_r == nnsag_pkg::DIM_BITS'(1)) begin
          frame_active_nxt = 1'b0;
          cols_nxt         = '0;
        end else begin
          dst_row_nxt  = dst_row_r + nnsag_pkg::ADDR_BITS'(lat_dst_stride_r);
          dst_addr_nxt = dst_row_nxt;
          src_row_nxt  = src_row_r + row_skip_r
                         + (y_step ? nnsag_pkg::ADDR_BITS'(lat_src_stride_r) : '0);
          src_addr_nxt = src_row_nxt;
          y_err_nxt    = y_step ? (y_sum - $signed({2'b00, y_den_r})) : y_sum;
          x_err_nxt    = -$signed({2'b00, x_den_r});
          cols_nxt     = lat_dst_width_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_active_r <= 1'b0;
      cols_r         <= '0;
      rows_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      frame_active_r <= frame_active_nxt;
      cols_r         <= cols_nxt;
      rows_r         <= rows_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    src_row_r  <= src_row_nxt;
    src_addr_r <= src_addr_nxt;
    dst_row_r  <= dst_row_nxt;
    dst_addr_r <= dst_addr_nxt;
    x_err_r    <= x_err_nxt;
    y_err_r    <= y_err_nxt;
    if (cmd.emit) begin
      out_src_r       <= src_addr_r;
      out_dst_r       <= dst_addr_r;
      out_row_end_r   <= (cols_r == nnsag_pkg::DIM_BITS'(1));
      out_frame_end_r <= (cols_r == nnsag_pkg::DIM_BITS'(1))
                         && (rows_r == nnsag_pkg::DIM_BITS'(1));
    end
  end

  assign sts.sizes_zero   = (src_width_r == '0) || (dst_width_r == '0)
                            || (src_height_r == '0) || (dst_height_r == '0);
  assign sts.div_done     = div_done;
  assign sts.frame_active = frame_active_r;
  assign sts.out_busy     = out_valid_r && out_stall;

  assign out_valid       = out_valid_r;
  assign out_src_address = out_src_r;
  assign out_dst_address = out_dst_r;
  assign out_row_end     = out_row_end_r;
  assign out_frame_end   = out_frame_end_r;

endmodule

/* design/nnsag_ctrl.sv */
// Controller: request acceptance and restart set-up sequencing
`include "nearest_neighbor_scale_address_gen_unit_assert.svh"

module nnsag_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_restart,
  output logic                in_stall,
  input  nnsag_pkg::status_t  sts,
  output nnsag_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIVX  = 3'd1;
  localparam logic [2:0] S_DIVY  = 3'd2;
  localparam logic [2:0] S_SETUP = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign in_stall = (state_r != S_IDLE) || sts.out_busy;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_restart) begin
            if (sts.sizes_zero) begin
              cmd.stop = 1'b1;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIVX;
            end
          end else if (sts.frame_active) begin
            cmd.emit = 1'b1;
          end
        end
      end
      S_DIVX: begin
        if (sts.div_done) begin
          cmd.cap_x     = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel_y = 1'b1;
          state_nxt     = S_DIVY;
        end
      end
      S_DIVY: begin
        if (sts.div_done) begin
          cmd.cap_y = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `NNSAG_ASSERT_NOW(a_emit_slot_free, cmd.emit, !sts.out_busy, "emit into a held output")
  `NNSAG_ASSERT_NEXT(a_divx_to_divy, (state_r == S_DIVX) && sts.div_done,
                     state_r == S_DIVY, "x division not followed by y division")
  `NNSAG_ASSERT_NEXT(a_first_pair_out, (state_r == S_EMIT) && !sts.out_busy,
                     state_r == S_IDLE, "first pair of frame lost")

endmodule

/* design/nearest_neighbor_scale_address_gen_unit.sv */
// Top level of the nearest-neighbor scale address generator
// Tick: a tick request accepted during a frame gives its pair in the output register the next cycle.
// Throughput: ticks run at one pair per cycle while out_stall does not hold the output register.
// Restart: the shared one-bit-per-cycle divider runs for x then y, before set-up.
// Reset: synchronous active-low rst_n clears the config registers, ends any frame, empties output.
module nearest_neighbor_scale_address_gen_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [nnsag_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  nnsag_pkg::addr_t                    cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output nnsag_pkg::addr_t                    out_src_address,
  output nnsag_pkg::addr_t                    out_dst_address,
  output logic                                out_row_end,
  output logic                                out_frame_end
);

  nnsag_pkg::cmd_t    cmd;
  nnsag_pkg::status_t sts;

  nnsag_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_restart (in_restart),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  nnsag_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .sts             (sts),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_src_address (out_src_address),
    .out_dst_address (out_dst_address),
    .out_row_end     (out_row_end),
    .out_frame_end   (out_frame_end)
  );

endmodule
